// ===== hdl/svhi_pkg.sv =====
// Shared constants and types for the state vector Hermite interpolator.
`timescale 1ns / 1ps
`default_nettype none
package svhi_pkg;
  localparam int AXIS_WIDTH  = 2;
  localparam int OUT_ERR_BIT = AXIS_WIDTH;
  localparam int OUT_SAT_BIT = AXIS_WIDTH + 1;
  localparam int OUT_USER_W  = AXIS_WIDTH + 2;
  typedef logic [AXIS_WIDTH-1:0] axis_t;
endpackage
`default_nettype wire

// ===== hdl/svhi_dly.sv =====
// Enabled delay line of fixed length.
`timescale 1ns / 1ps
`default_nettype none
module svhi_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= d;
      for (int i = 1; i < N; i++) begin
        r[i] <= r[i-1];
      end
    end
  end

  assign q = r[N-1];
endmodule
`default_nettype wire

// ===== hdl/svhi_mul.sv =====
// Two-stage saturating fixed point multiplier, rounding ties away from zero.
`timescale 1ns / 1ps
`default_nettype none
module svhi_mul #(
  parameter int DATA_WIDTH    = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic [DATA_WIDTH-1:0] p,
  output logic                  sat
);
  localparam int DW = DATA_WIDTH;
  localparam int H  = (DW + 1) / 2;
  localparam int HW = DW - H;
  localparam int PW = 2 * DW + 1;
  localparam logic [PW-1:0] RND = PW'(1) << (FRACTION_BITS - 1);
  localparam logic [PW-1:0] LIM = PW'(1) << (DW - 1);

  logic [DW-1:0]    ma, mb;
  logic [2*H-1:0]   ll;
  logic [H+HW-1:0]  lh, hl;
  logic [2*HW-1:0]  hh;
  logic             neg;
  logic [PW-1:0]    full, sh, lim;

  always_comb begin
    ma = a[DW-1] ? DW'(0) - a : a;
    mb = b[DW-1] ? DW'(0) - b : b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll  <= ma[H-1:0] * mb[H-1:0];
      lh  <= ma[H-1:0] * mb[DW-1:H];
      hl  <= ma[DW-1:H] * mb[H-1:0];
      hh  <= ma[DW-1:H] * mb[DW-1:H];
      neg <= a[DW-1] ^ b[DW-1];
    end
  end

  always_comb begin
    full = PW'(ll) + (PW'(lh) << H) + (PW'(hl) << H) + (PW'(hh) << (2 * H)) + RND;
    sh   = full >> FRACTION_BITS;
    lim  = neg ? LIM : LIM - PW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > lim) begin
        sat <= 1'b1;
        p   <= neg ? DW'(LIM) : DW'(LIM - PW'(1));
      end else begin
        sat <= 1'b0;
        p   <= neg ? DW'(0) - sh[DW-1:0] : sh[DW-1:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/svhi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated.
`timescale 1ns / 1ps
`default_nettype none
module svhi_div #(
  parameter int DATA_WIDTH    = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [DATA_WIDTH-1:0] n,
  input  logic [DATA_WIDTH-1:0] d,
  output logic [DATA_WIDTH-1:0] q,
  output logic                  sat
);
  localparam int DW = DATA_WIDTH;
  localparam int NW = DW + FRACTION_BITS + 1;
  localparam int RW = DW + 1;
  localparam logic [NW-1:0] LIM = NW'(1) << (DW - 1);

  logic [DW-1:0] un, ud_in;
  logic [RW-1:0] rem [NW+1];
  logic [NW-1:0] num [NW+1];
  logic [NW-1:0] quo [NW+1];
  logic [DW-1:0] dv  [NW+1];
  logic          neg [NW+1];
  logic [NW-1:0] lim;

  always_comb begin
    un    = n[DW-1] ? DW'(0) - n : n;
    ud_in = d[DW-1] ? DW'(0) - d : d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      num[0] <= (NW'(un) << FRACTION_BITS) + NW'(ud_in >> 1);
      quo[0] <= '0;
      dv[0]  <= ud_in;
      neg[0] <= n[DW-1] ^ d[DW-1];
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = {rem[k][RW-2:0], num[k][NW-1]};
    assign ge = sh >= RW'(dv[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? sh - RW'(dv[k]) : sh;
        num[k+1] <= num[k] << 1;
        quo[k+1] <= {quo[k][NW-2:0], ge};
        dv[k+1]  <= dv[k];
        neg[k+1] <= neg[k];
      end
    end
  end

  assign lim = neg[NW] ? LIM : LIM - NW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (quo[NW] > lim) begin
        sat <= 1'b1;
        q   <= neg[NW] ? DW'(LIM) : DW'(LIM - NW'(1));
      end else begin
        sat <= 1'b0;
        q   <= neg[NW] ? DW'(0) - quo[NW][DW-1:0] : quo[NW][DW-1:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/state_vector_hermite_interp_top.sv =====
// Top level of the pipelined cubic Hermite state vector interpolator.
//
//  channel | dir | tdata                                   | tuser
//  s_*     | in  | start_pos start_vel end_pos end_vel      | axis
//          |     | start_time end_time query_time           |
//  m_*     | out | out_pos out_vel                          | axis_out error_flag saturated
//
// One item enters per cycle while the output is not stalled; most of the pipeline
// depth lies in the two bit-per-stage dividers (time normalisation and velocity scaling).
// The whole pipeline advances together; a result held at the output stalls it.
// rst clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module state_vector_hermite_interp_top
  import svhi_pkg::*;
#(
  parameter int DATA_WIDTH    = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_pos, start_vel, end_pos, end_vel, start_time, end_time, query_time
  input  logic [((7*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // axis
  input  logic [AXIS_WIDTH-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_pos, out_vel
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // axis_out, error_flag, saturated
  output logic [OUT_USER_W-1:0] m_tuser
);
  localparam int DW  = DATA_WIDTH;
  localparam int LD  = DW + FRACTION_BITS + 3;
  localparam int F   = 2 * LD + 7;
  localparam int OTW = ((2*DATA_WIDTH+7)/8)*8;
  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [DW:0] sadd(input logic [DW-1:0] x, input logic [DW-1:0] y);
    logic [DW:0] s;
    s = {x[DW-1], x} + {y[DW-1], y};
    if (s[DW] != s[DW-1]) sadd = {1'b1, s[DW] ? SMIN : SMAX};
    else sadd = {1'b0, s[DW-1:0]};
  endfunction

  function automatic logic [DW:0] ssub(input logic [DW-1:0] x, input logic [DW-1:0] y);
    logic [DW:0] s;
    s = {x[DW-1], x} - {y[DW-1], y};
    if (s[DW] != s[DW-1]) ssub = {1'b1, s[DW] ? SMIN : SMAX};
    else ssub = {1'b0, s[DW-1:0]};
  endfunction

  logic          en;
  logic [F-1:0]  vsh;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vsh <= '0;
    end else if (en) begin
      vsh <= {vsh[F-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vsh[F-1];

  // stage 1
  logic [DW-1:0] ia, iva, ib, ivb, it0, it1, itq;
  logic [DW:0]   r_sp, r_q, r_a2, r_a3, r_b2, r_b3, r_c2a, r_c3a;
  axis_t         axis1;
  logic          err1, sat1;
  logic [DW-1:0] span1, q1, c2a1, c3a1, a1, va1, vb1;

  assign ia  = s_tdata[0*DW +: DW];
  assign iva = s_tdata[1*DW +: DW];
  assign ib  = s_tdata[2*DW +: DW];
  assign ivb = s_tdata[3*DW +: DW];
  assign it0 = s_tdata[4*DW +: DW];
  assign it1 = s_tdata[5*DW +: DW];
  assign itq = s_tdata[6*DW +: DW];

  always_comb begin
    r_sp  = ssub(it1, it0);
    r_q   = ssub(itq, it0);
    r_b2  = sadd(ib, ib);
    r_b3  = sadd(r_b2[DW-1:0], ib);
    r_a2  = sadd(ia, ia);
    r_a3  = sadd(r_a2[DW-1:0], ia);
    r_c2a = ssub(r_b3[DW-1:0], r_a3[DW-1:0]);
    r_c3a = ssub(r_a2[DW-1:0], r_b2[DW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axis1 <= s_tuser;
      err1  <= it1 == it0;
      span1 <= r_sp[DW-1:0];
      q1    <= r_q[DW-1:0];
      c2a1  <= r_c2a[DW-1:0];
      c3a1  <= r_c3a[DW-1:0];
      a1    <= ia;
      va1   <= iva;
      vb1   <= ivb;
      sat1  <= r_sp[DW] | r_q[DW] | r_b2[DW] | r_b3[DW] | r_a2[DW] | r_a3[DW]
             | r_c2a[DW] | r_c3a[DW];
    end
  end

  // velocity terms and coefficients
  logic [DW-1:0] av3, bv3, c2a3, c3a3;
  logic          avs3, bvs3, sat1_3;
  logic [DW:0]   r_av2, r_x, r_c2, r_y, r_c3, r_c2x2, r_c3x2, r_c3x3;
  logic [DW-1:0] c2_4, c3_4, c2x2_5, c3x3_5;
  logic          sat4, sat5;

  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_av (
    .clk(clk), .en(en), .a(va1), .b(span1), .p(av3), .sat(avs3));
  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_bv (
    .clk(clk), .en(en), .a(vb1), .b(span1), .p(bv3), .sat(bvs3));
  svhi_dly #(.W(2*DW+1), .N(2)) u_dly_c (
    .clk(clk), .en(en), .d({sat1, c3a1, c2a1}), .q({sat1_3, c3a3, c2a3}));

  always_comb begin
    r_av2  = sadd(av3, av3);
    r_x    = ssub(c2a3, r_av2[DW-1:0]);
    r_c2   = ssub(r_x[DW-1:0], bv3);
    r_y    = sadd(c3a3, av3);
    r_c3   = sadd(r_y[DW-1:0], bv3);
    r_c2x2 = sadd(c2_4, c2_4);
    r_c3x2 = sadd(c3_4, c3_4);
    r_c3x3 = sadd(r_c3x2[DW-1:0], c3_4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_4   <= r_c2[DW-1:0];
      c3_4   <= r_c3[DW-1:0];
      sat4   <= sat1_3 | avs3 | bvs3 | r_av2[DW] | r_x[DW] | r_c2[DW] | r_y[DW] | r_c3[DW];
      c2x2_5 <= r_c2x2[DW-1:0];
      c3x3_5 <= r_c3x3[DW-1:0];
      sat5   <= sat4 | r_c2x2[DW] | r_c3x2[DW] | r_c3x3[DW];
    end
  end

  // normalised time
  logic [DW-1:0] tT, tT2, avT, avT2, c2x2T, c2T2, c3x3T2, c3T4, aT2, spanT5;
  logic          tsT, tsT2, sat5T2;

  svhi_div #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_div_t (
    .clk(clk), .en(en), .n(q1), .d(span1), .q(tT), .sat(tsT));
  svhi_dly #(.W(DW+1), .N(2)) u_dly_t (
    .clk(clk), .en(en), .d({tsT, tT}), .q({tsT2, tT2}));
  svhi_dly #(.W(DW), .N(LD-2)) u_dly_av (
    .clk(clk), .en(en), .d(av3), .q(avT));
  svhi_dly #(.W(DW), .N(2)) u_dly_av2 (
    .clk(clk), .en(en), .d(avT), .q(avT2));
  svhi_dly #(.W(DW), .N(LD-4)) u_dly_c2x2 (
    .clk(clk), .en(en), .d(c2x2_5), .q(c2x2T));
  svhi_dly #(.W(DW), .N(LD-1)) u_dly_c2 (
    .clk(clk), .en(en), .d(c2_4), .q(c2T2));
  svhi_dly #(.W(DW+1), .N(LD-2)) u_dly_c3x3 (
    .clk(clk), .en(en), .d({sat5, c3x3_5}), .q({sat5T2, c3x3T2}));
  svhi_dly #(.W(DW), .N(LD+1)) u_dly_c3 (
    .clk(clk), .en(en), .d(c3_4), .q(c3T4));
  svhi_dly #(.W(DW), .N(LD+2)) u_dly_a (
    .clk(clk), .en(en), .d(a1), .q(aT2));
  svhi_dly #(.W(DW), .N(LD+5)) u_dly_span (
    .clk(clk), .en(en), .d(span1), .q(spanT5));

  // polynomial evaluation
  logic [DW-1:0] t2, avt, c2t, t3, c2t2, c3t2, c3t3;
  logic          t2s, avts, c2ts, t3s, c2t2s, c3t2s, c3t3s;
  logic [DW:0]   r_p1, r_v1, r_p2, r_vn, r_pos;
  logic [DW-1:0] pos1, vn1, pos1d, vn1d, pos2, vn, pos2d, pos;
  logic          satp1, satp1d, satp2, satp2d, satp3;

  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_t2 (
    .clk(clk), .en(en), .a(tT), .b(tT), .p(t2), .sat(t2s));
  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_avt (
    .clk(clk), .en(en), .a(avT), .b(tT), .p(avt), .sat(avts));
  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_c2t (
    .clk(clk), .en(en), .a(c2x2T), .b(tT), .p(c2t), .sat(c2ts));
  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_t3 (
    .clk(clk), .en(en), .a(t2), .b(tT2), .p(t3), .sat(t3s));
  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_c2t2 (
    .clk(clk), .en(en), .a(c2T2), .b(t2), .p(c2t2), .sat(c2t2s));
  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_c3t2 (
    .clk(clk), .en(en), .a(c3x3T2), .b(t2), .p(c3t2), .sat(c3t2s));
  svhi_mul #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_mul_c3t3 (
    .clk(clk), .en(en), .a(c3T4), .b(t3), .p(c3t3), .sat(c3t3s));

  always_comb begin
    r_p1  = sadd(aT2, avt);
    r_v1  = sadd(avT2, c2t);
    r_p2  = sadd(pos1d, c2t2);
    r_vn  = sadd(vn1d, c3t2);
    r_pos = sadd(pos2d, c3t3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos1  <= r_p1[DW-1:0];
      vn1   <= r_v1[DW-1:0];
      satp1 <= sat5T2 | tsT2 | t2s | avts | c2ts | r_p1[DW] | r_v1[DW];
      pos2  <= r_p2[DW-1:0];
      vn    <= r_vn[DW-1:0];
      satp2 <= satp1d | t3s | c2t2s | c3t2s | r_p2[DW] | r_vn[DW];
      pos   <= r_pos[DW-1:0];
      satp3 <= satp2d | c3t3s | r_pos[DW];
    end
  end

  svhi_dly #(.W(2*DW+1), .N(1)) u_dly_p1 (
    .clk(clk), .en(en), .d({satp1, vn1, pos1}), .q({satp1d, vn1d, pos1d}));
  svhi_dly #(.W(DW+1), .N(1)) u_dly_p2 (
    .clk(clk), .en(en), .d({satp2, pos2}), .q({satp2d, pos2d}));

  // velocity scaling and output
  logic [DW-1:0] vel, posF;
  logic          vels, satF, errF;
  axis_t         axisF;

  svhi_div #(.DATA_WIDTH(DW), .FRACTION_BITS(FRACTION_BITS)) u_div_v (
    .clk(clk), .en(en), .n(vn), .d(spanT5), .q(vel), .sat(vels));
  svhi_dly #(.W(DW+1), .N(LD-2)) u_dly_pos (
    .clk(clk), .en(en), .d({satp3, pos}), .q({satF, posF}));
  svhi_dly #(.W(AXIS_WIDTH+1), .N(2*LD+5)) u_dly_axis (
    .clk(clk), .en(en), .d({err1, axis1}), .q({errF, axisF}));

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser[AXIS_WIDTH-1:0] <= axisF;
      m_tuser[OUT_ERR_BIT]    <= errF;
      m_tuser[OUT_SAT_BIT]    <= !errF && (satF || vels);
      m_tdata                 <= errF ? '0 : OTW'({vel, posF});
    end
  end
endmodule
`default_nettype wire

// ===== hdl/svhi_chk.sv =====
// Port checker for the Hermite interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module svhi_chk
  import svhi_pkg::*;
#(
  parameter int DATA_WIDTH = 48
) (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output transfer changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[OUT_ERR_BIT] |-> m_tdata == '0 && !m_tuser[OUT_SAT_BIT])
    else $error("zero span result not cleared");
endmodule

bind state_vector_hermite_interp_top svhi_chk #(.DATA_WIDTH(DATA_WIDTH)) u_svhi_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));
`default_nettype wire

// ===== tb/svhi_checker.sv =====
// Checker for the Hermite interpolator: predicts each transfer's result and compares.
`timescale 1ns / 1ps
module svhi_checker
  import svhi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [335:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,
  input  logic [3:0]   m_tuser,
  output int           fail_count,
  output int           outstanding
);
  typedef logic signed [47:0]  q_t;
  typedef logic signed [127:0] w_t;

  localparam w_t Q_MAX = (w_t'(1) <<< 47) - 1;
  localparam w_t Q_MIN = -(w_t'(1) <<< 47);

  typedef struct packed {
    axis_t axis;
    q_t    pos;
    q_t    vel;
    logic  err;
    logic  sat;
  } interp_t;

  interp_t interp_q[$];
  logic    clamped;

  function automatic q_t clamp(w_t x);
    if (x > Q_MAX) begin
      clamped = 1'b1;
      return q_t'(Q_MAX);
    end
    if (x < Q_MIN) begin
      clamped = 1'b1;
      return q_t'(Q_MIN);
    end
    return q_t'(x);
  endfunction

  function automatic q_t qmul(q_t a, q_t b);
    w_t p;
    w_t m;
    logic neg;
    p = w_t'(a) * w_t'(b);
    neg = p < 0;
    m = neg ? -p : p;
    m = (m + w_t'(32768)) >>> 16;
    return clamp(neg ? -m : m);
  endfunction

  function automatic q_t qdiv(q_t n, q_t d);
    w_t nm;
    w_t dm;
    w_t r;
    logic neg;
    neg = (n < 0) != (d < 0);
    nm = (n < 0) ? -w_t'(n) : w_t'(n);
    dm = (d < 0) ? -w_t'(d) : w_t'(d);
    r = ((nm <<< 16) + (dm >>> 1)) / dm;
    return clamp(neg ? -r : r);
  endfunction

  function automatic q_t qadd(q_t a, q_t b);
    return clamp(w_t'(a) + w_t'(b));
  endfunction

  function automatic q_t qsub(q_t a, q_t b);
    return clamp(w_t'(a) - w_t'(b));
  endfunction

  function automatic interp_t hermite_predict(logic [335:0] d, axis_t ax);
    interp_t r;
    q_t a, va, b, vb, t0, t1, tq;
    q_t span, q, av, bv, c2, c3, t, t2, t3, pos, vn;
    a  = d[47:0];
    va = d[95:48];
    b  = d[143:96];
    vb = d[191:144];
    t0 = d[239:192];
    t1 = d[287:240];
    tq = d[335:288];
    r.axis = ax;
    clamped = 1'b0;
    if (t1 == t0) begin
      r.pos = '0;
      r.vel = '0;
      r.err = 1'b1;
      r.sat = 1'b0;
      return r;
    end
    span = qsub(t1, t0);
    q    = qsub(tq, t0);
    av   = qmul(va, span);
    bv   = qmul(vb, span);
    c2   = qsub(qadd(qadd(b, b), b), qadd(qadd(a, a), a));
    c2   = qsub(c2, qadd(av, av));
    c2   = qsub(c2, bv);
    c3   = qsub(qadd(a, a), qadd(b, b));
    c3   = qadd(c3, av);
    c3   = qadd(c3, bv);
    t    = qdiv(q, span);
    t2   = qmul(t, t);
    t3   = qmul(t2, t);
    pos  = qadd(a, qmul(av, t));
    pos  = qadd(pos, qmul(c2, t2));
    pos  = qadd(pos, qmul(c3, t3));
    vn   = qadd(av, qmul(qadd(c2, c2), t));
    vn   = qadd(vn, qmul(qadd(qadd(c3, c3), c3), t2));
    r.vel = qdiv(vn, span);
    r.pos = pos;
    r.err = 1'b0;
    r.sat = clamped;
    return r;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    interp_t e;
    if (!rst && s_tvalid && s_tready)
      interp_q.push_back(hermite_predict(s_tdata, s_tuser));
    if (!rst && m_tvalid && m_tready) begin
      if (interp_q.size() == 0) begin
        $error("unexpected result transfer: tdata %h tuser %h", m_tdata, m_tuser);
        fail_count++;
      end else begin
        e = interp_q.pop_front();
        if (m_tuser[1:0] !== e.axis) begin
          $error("axis_out: expected %0d, got %0d", e.axis, m_tuser[1:0]);
          fail_count++;
        end
        if (m_tdata[47:0] !== e.pos) begin
          $error("out_pos: expected %0d, got %0d", e.pos, $signed(m_tdata[47:0]));
          fail_count++;
        end
        if (m_tdata[95:48] !== e.vel) begin
          $error("out_vel: expected %0d, got %0d", e.vel, $signed(m_tdata[95:48]));
          fail_count++;
        end
        if (m_tuser[OUT_ERR_BIT] !== e.err) begin
          $error("error_flag: expected %0b, got %0b", e.err, m_tuser[OUT_ERR_BIT]);
          fail_count++;
        end
        if (m_tuser[OUT_SAT_BIT] !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, m_tuser[OUT_SAT_BIT]);
          fail_count++;
        end
      end
    end
    outstanding = interp_q.size();
  end
endmodule

// ===== tb/testbench.sv =====
// Stimulus and verdict for the Hermite state vector interpolator.
`timescale 1ns / 1ps
module testbench;
  import svhi_pkg::*;

  typedef logic signed [47:0] q_t;

  localparam int  LATENCY   = 2 * (48 + 16 + 3) + 7;
  localparam int  CYCLE_CAP = 600000;
  localparam q_t  Q_MAX     = 48'sh7FFF_FFFF_FFFF;
  localparam q_t  Q_MIN     = 48'sh8000_0000_0000;
  localparam q_t  ONE       = 48'sh1_0000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [335:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [3:0]   m_tuser;
  int           fail_count;
  int           outstanding;
  int           cycles = 0;
  int           results_seen = 0;

  always #5 clk = ~clk;

  state_vector_hermite_interp_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  svhi_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("state_vector_hermite_interp_top: mismatch");
      $finish;
    end
  end

  function automatic q_t rnd_full();
    return q_t'({$urandom, $urandom});
  endfunction

  // signed value with magnitude below 2^k
  function automatic q_t rnd_bits(int k);
    logic [63:0] r;
    r = {$urandom, $urandom} & ((64'd1 << k) - 1);
    return $urandom_range(0, 1) ? -q_t'(r) : q_t'(r);
  endfunction

  int burst_s = 0;

  task automatic send(q_t a, q_t va, q_t b, q_t vb, q_t t0, q_t t1, q_t tq, axis_t ax);
    int gap;
    gap = (burst_s > 0) ? 0 : $urandom_range(0, 16);
    if (burst_s > 0) burst_s--;
    else if ($urandom_range(0, 40) == 0) burst_s = $urandom_range(10, 60);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {tq, t1, t0, vb, b, va, a};
    s_tuser  <= ax;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random();
    q_t t0, span, tq;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      send(rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
           rnd_full(), axis_t'($urandom));
    end else if (kind == 1) begin
      t0 = rnd_full();
      send(rnd_full(), rnd_full(), rnd_full(), rnd_full(), t0, t0, rnd_full(),
           axis_t'($urandom));
    end else begin
      t0 = rnd_bits(32);
      span = rnd_bits($urandom_range(8, 26));
      if (span == 0) span = ONE;
      if ($urandom_range(0, 4) == 0) tq = t0 + rnd_bits(30);
      else tq = t0 + q_t'((longint'(span) * longint'($urandom_range(0, 1024))) / 1024);
      send(rnd_bits(40), rnd_bits(30), rnd_bits(40), rnd_bits(30), t0, t0 + span, tq,
           axis_t'($urandom_range(0, 2)));
    end
  endtask

  // receiver: random stalls, bursts without stalls, one long hold-off
  initial begin
    int stall;
    int burst_m;
    burst_m = 0;
    @(negedge rst);
    forever begin
      stall = (burst_m > 0) ? 0 : $urandom_range(0, 16);
      if (burst_m > 0) burst_m--;
      else if ($urandom_range(0, 40) == 0) burst_m = $urandom_range(10, 60);
      if (results_seen == 200) stall = 2000;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      results_seen++;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, zero span, unused axis code, edge query times
    send(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 2'd0);
    send(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, 2'd1);
    send(Q_MAX, Q_MIN, Q_MIN, Q_MAX, '0, ONE, ONE >>> 1, 2'd2);
    send(Q_MIN, Q_MAX, Q_MAX, Q_MIN, '0, ONE, Q_MAX, 2'd3);
    send(ONE, ONE, ONE, ONE, ONE, ONE, ONE, 2'd0);
    send(Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 2'd3);
    send('0, '0, '0, '0, '0, '0, '0, 2'd1);
    send(ONE * 10, ONE, ONE * 20, ONE, '0, ONE * 10, '0, 2'd0);
    send(ONE * 10, ONE, ONE * 20, ONE, '0, ONE * 10, ONE * 10, 2'd1);
    send(ONE * 10, ONE, ONE * 20, ONE, '0, ONE * 10, ONE * 5, 2'd2);
    send(ONE * 10, ONE, ONE * 20, ONE, '0, ONE * 10, ONE * 30, 2'd0);
    send(ONE * 10, ONE, ONE * 20, ONE, '0, ONE * 10, -ONE * 40, 2'd1);
    send(-ONE * 7, ONE * 3, ONE * 9, -ONE, ONE * 100, ONE * 90, ONE * 95, 2'd2);
    send(ONE, '0, -ONE, '0, '0, 48'sd1, '0, 2'd0);
    send(ONE, ONE, -ONE, ONE, '0, 48'sd1, 48'sd1, 2'd1);
    send(Q_MAX >>> 2, ONE, Q_MIN >>> 2, -ONE, '0, ONE * 1000, ONE * 999, 2'd2);
    send(-ONE, 48'sd3, ONE, -48'sd3, ONE, ONE * 3, ONE * 2, 2'd3);
    send(ONE * 5, ONE * 2, ONE * 5, ONE * 2, Q_MIN, Q_MIN + ONE, Q_MIN, 2'd0);
    repeat (1800) send_random();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("state_vector_hermite_interp_top: match");
    else
      $display("state_vector_hermite_interp_top: mismatch");
    $finish;
  end
endmodule
